// ===== rtl/afhd_pkg.sv =====
`timescale 1ns / 1ps

package afhd_pkg;

    // Frame layout
    localparam logic [16:0] HDR_BYTES = 17'd40;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;

    // Magic bytes at the head of every frame, in arrival order
    localparam logic [7:0] MAGIC [4] = '{8'h56, 8'h53, 8'h41, 8'h31};
    localparam logic [7:0] VERSION = 8'h01;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Report status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

    // Fixed-width header fields carried by a report
    typedef struct packed {
        logic [63:0] stream_id_low;
        logic [63:0] stream_id_high;
        logic [63:0] timestamp;
        logic [31:0] sequence_res;
        logic        direction;
    } afhd_hdr_t;

    // Per-result control and small fields
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       end_of_run;
    } afhd_res_t;

endpackage

// ===== rtl/afhd_frame_core.sv =====
`timescale 1ns / 1ps

module afhd_frame_core
    import afhd_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic                    advance,
    input  logic [15:0]             max_payload,
    output logic                    consume,
    output afhd_res_t               res,
    output afhd_hdr_t               res_hdr,
    output logic [LENGTH_WIDTH-1:0] res_length
);

    localparam logic [32:0] LEN_LIMIT = (33'd1 << LENGTH_WIDTH) - 33'd1;

    logic [16:0] byte_count_reg, byte_count_next;
    logic        header_good_reg, header_good_next;
    logic [31:0] seq_reg, seq_next;
    logic [63:0] time_reg, time_next;
    logic [63:0] id_high_reg, id_high_next;
    logic [63:0] id_low_reg, id_low_next;
    logic [31:0] declared_reg, declared_next;
    logic        dir_reg, dir_next;
    logic        phase_reg, phase_next;

    logic [16:0] pos;
    logic [16:0] payload_pos;
    logic        forward;
    logic        split;
    logic        emit;
    logic [1:0]  status;

    assign pos = byte_count_reg;
    assign payload_pos = pos - HDR_BYTES;

    // Header checks and big-endian field capture for the byte at hand
    always_comb
    begin
        header_good_next = header_good_reg;
        seq_next         = seq_reg;
        time_next        = time_reg;
        id_high_next     = id_high_reg;
        id_low_next      = id_low_reg;
        declared_next    = declared_reg;
        dir_next         = dir_reg;
        if (pos < 17'd4)
        begin
            if (in_byte != MAGIC[pos[1:0]])
            begin
                header_good_next = 1'b0;
            end
        end
        else if (pos == 17'd4)
        begin
            if (in_byte != VERSION)
            begin
                header_good_next = 1'b0;
            end
        end
        else if (pos == 17'd5)
        begin
            if (in_byte > 8'd1)
            begin
                header_good_next = 1'b0;
            end
            dir_next = in_byte[0];
        end
        else if (pos < 17'd8)
        begin
            if (in_byte != 8'd0)
            begin
                header_good_next = 1'b0;
            end
        end
        else if (pos < 17'd12)
        begin
            seq_next = {seq_reg[23:0], in_byte};
        end
        else if (pos < 17'd20)
        begin
            time_next = {time_reg[55:0], in_byte};
        end
        else if (pos < 17'd28)
        begin
            id_high_next = {id_high_reg[55:0], in_byte};
        end
        else if (pos < 17'd36)
        begin
            id_low_next = {id_low_reg[55:0], in_byte};
        end
        else if (pos < HDR_BYTES)
        begin
            declared_next = {declared_reg[23:0], in_byte};
        end
    end

    // Saturating byte counter
    assign byte_count_next = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 17'd1
                                                           : byte_count_reg;

    // A payload byte is forwarded while inside the declared length and the header is good
    assign forward = (pos >= HDR_BYTES) && header_good_reg
                     && ({15'd0, payload_pos} < declared_reg);

    // Status of the end-of-frame report, taken from the updated state
    always_comb
    begin
        if ((byte_count_next < HDR_BYTES) || !header_good_next)
        begin
            status = STATUS_BAD_HDR;
        end
        else if ((declared_next > {16'd0, max_payload})
                 || ({16'd0, byte_count_next} != ({1'b0, declared_next} + 33'd40)))
        begin
            status = STATUS_BAD_SIZE;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // Result selection: a final payload byte gives its payload first, then its report
    assign split = forward && in_last && !phase_reg;

    always_comb
    begin
        res         = '0;
        res_hdr     = '0;
        res_length  = '0;
        res.valid   = in_valid && (phase_reg || forward || in_last);
        if (forward && !phase_reg)
        begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = in_byte;
            res.end_of_run   = !in_last;
        end
        else
        begin
            res.kind                = KIND_REPORT;
            res.status              = status;
            res.end_of_run          = 1'b1;
            res_hdr.direction       = dir_next;
            res_hdr.sequence_res    = seq_next;
            res_hdr.timestamp       = time_next;
            res_hdr.stream_id_high  = id_high_next;
            res_hdr.stream_id_low   = id_low_next;
            if ({1'b0, declared_next} > LEN_LIMIT)
            begin
                res_length = LEN_LIMIT[LENGTH_WIDTH-1:0];
            end
            else
            begin
                res_length = declared_next[LENGTH_WIDTH-1:0];
            end
        end
    end

    // The item leaves once its last result is taken; items with no result leave at once
    assign emit    = res.valid && advance;
    assign consume = in_valid && (res.valid ? (advance && !split) : 1'b1);

    always_comb
    begin
        phase_next = phase_reg;
        if (consume)
        begin
            phase_next = 1'b0;
        end
        else if (emit && split)
        begin
            phase_next = 1'b1;
        end
    end

    // Frame state: updated on consume, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            header_good_reg <= 1'b1;
            seq_reg         <= '0;
            time_reg        <= '0;
            id_high_reg     <= '0;
            id_low_reg      <= '0;
            declared_reg    <= '0;
            dir_reg         <= 1'b0;
            phase_reg       <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (consume)
            begin
                if (in_last)
                begin
                    byte_count_reg  <= '0;
                    header_good_reg <= 1'b1;
                    seq_reg         <= '0;
                    time_reg        <= '0;
                    id_high_reg     <= '0;
                    id_low_reg      <= '0;
                    declared_reg    <= '0;
                    dir_reg         <= 1'b0;
                end
                else
                begin
                    byte_count_reg  <= byte_count_next;
                    header_good_reg <= header_good_next;
                    seq_reg         <= seq_next;
                    time_reg        <= time_next;
                    id_high_reg     <= id_high_next;
                    id_low_reg      <= id_low_next;
                    declared_reg    <= declared_next;
                    dir_reg         <= dir_next;
                end
            end
        end
    end

endmodule

// ===== rtl/audio_frame_header_deframer.sv =====
`timescale 1ns / 1ps
// Each accepted item is held in the input register, and its result is then registered in
// the result register that drives the master side; either register holds while stalled.
// Throughput: one item per cycle while the master side takes results; a final byte that
// is also a payload byte yields two results and holds the input register for the report.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the frame
// state and sets max_payload_bytes to 4096.

module audio_frame_header_deframer
    import afhd_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: max_payload_bytes
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    // Slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,  // data_byte
    input  logic                s_tlast,  // frame_end
    // Master side
    output logic                m_tvalid,
    input  logic                m_tready,
    // payload_byte, direction, sequence_res, timestamp, stream_id_high,
    // stream_id_low, payload_length, status, zero fill
    output logic [((235 + LENGTH_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                m_tuser,  // kind
    output logic                m_tlast   // end_of_run
);

    localparam int FIELD_BITS = 235 + LENGTH_WIDTH;

    logic [15:0]             max_reg;
    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0]   out_fields_reg;
    logic                    out_kind_reg;
    logic                    out_last_reg;
    logic                    advance;
    logic                    consume;
    logic                    accept;
    afhd_res_t               res;
    afhd_hdr_t               res_hdr;
    logic [LENGTH_WIDTH-1:0] res_length;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_reg <= cfg_wdata;
        end
    end

    // Input register: refills in the same cycle the held item leaves
    assign s_tready = !in_valid_reg || consume;
    assign accept   = s_tvalid && s_tready;
    assign in_valid_next = accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    afhd_frame_core #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .advance    (advance),
        .max_payload(max_reg),
        .consume    (consume),
        .res        (res),
        .res_hdr    (res_hdr),
        .res_length (res_length)
    );

    // Result register
    assign advance = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_fields_reg <= {res.status, res_length, res_hdr.stream_id_low,
                               res_hdr.stream_id_high, res_hdr.timestamp,
                               res_hdr.sequence_res, res_hdr.direction, res.payload_byte};
            out_kind_reg   <= res.kind;
            out_last_reg   <= res.end_of_run;
        end
    end

    // Master side outputs
    always_comb
    begin
        m_tdata = '0;
        m_tdata[FIELD_BITS-1:0] = out_fields_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== test/afhd_checker.sv =====
`timescale 1ns / 1ps

module afhd_frame_checker
    import afhd_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [15:0]                                   cfg_wdata,
    input  logic                                          s_tvalid,
    input  logic                                          s_tready,
    input  logic [7:0]                                    s_tdata,
    input  logic                                          s_tlast,
    input  logic                                          m_tvalid,
    input  logic                                          m_tready,
    input  logic [((235 + LENGTH_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                                          m_tuser,
    input  logic                                          m_tlast,
    output int                                            errors,
    output int                                            pending
);

    // Byte positions of the fixed header bytes, and the end position (exclusive) of each captured field.
    localparam logic [16:0] POS_VERSION  = 17'd4;
    localparam logic [16:0] POS_DIR      = 17'd5;
    localparam logic [16:0] POS_RSVD_A   = 17'd6;
    localparam logic [16:0] POS_RSVD_B   = 17'd7;
    localparam logic [16:0] SEQ_END      = 17'd12;
    localparam logic [16:0] TIME_END     = 17'd20;
    localparam logic [16:0] ID_HIGH_END  = 17'd28;
    localparam logic [16:0] ID_LOW_END   = 17'd36;
    localparam logic [31:0] PLEN_MAX     = (LENGTH_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                           32'((64'd1 << LENGTH_WIDTH) - 64'd1);
    localparam int          PLEN_LSB     = 233;
    localparam int          STATUS_LSB   = 233 + LENGTH_WIDTH;
    localparam int          SHOWN_ERRORS = 10;

    typedef struct packed {
        logic                    kind;
        logic [7:0]              pbyte;
        logic                    dir;
        logic [31:0]             seq;
        logic [63:0]             ts;
        logic [63:0]             idh;
        logic [63:0]             idl;
        logic [LENGTH_WIDTH-1:0] plen;
        logic [1:0]              status;
        logic                    eor;
    } frame_result_t;

    // Shadow copy of the frame state and the size limit.
    logic [16:0]   byte_pos = '0;
    logic          hdr_ok = 1'b1;
    logic [31:0]   seq_acc = '0;
    logic [63:0]   ts_acc = '0;
    logic [63:0]   idh_acc = '0;
    logic [63:0]   idl_acc = '0;
    logic [31:0]   decl_len = '0;
    logic          dir_bit = 1'b0;
    logic [15:0]   max_len = MAX_PAYLOAD_RESET;

    frame_result_t owed_outputs[$];
    frame_result_t got;
    frame_result_t want;

    function automatic void clear_frame();
        byte_pos = '0;
        hdr_ok   = 1'b1;
        seq_acc  = '0;
        ts_acc   = '0;
        idh_acc  = '0;
        idl_acc  = '0;
        decl_len = '0;
        dir_bit  = 1'b0;
    endfunction

    function automatic string show(frame_result_t r);
        return $sformatf({"kind=%0d byte=%02h dir=%0d seq=%08h ts=%016h idh=%016h",
                          " idl=%016h len=%0h st=%0d last=%0d"},
                         r.kind, r.pbyte, r.dir, r.seq, r.ts, r.idh, r.idl, r.plen,
                         r.status, r.eor);
    endfunction

    // Advance the shadow deframer by one byte and queue the results it owes.
    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        logic [16:0]   pos;
        logic [32:0]   total;
        frame_result_t r;

        pos = byte_pos;
        if (pos < POS_VERSION)
        begin
            if (b != MAGIC[pos[1:0]])
                hdr_ok = 1'b0;
        end
        else if (pos == POS_VERSION)
        begin
            if (b != VERSION)
                hdr_ok = 1'b0;
        end
        else if (pos == POS_DIR)
        begin
            if (b > 8'd1)
                hdr_ok = 1'b0;
            dir_bit = b[0];
        end
        else if (pos == POS_RSVD_A || pos == POS_RSVD_B)
        begin
            if (b != 8'd0)
                hdr_ok = 1'b0;
        end
        else if (pos < SEQ_END)
            seq_acc = {seq_acc[23:0], b};
        else if (pos < TIME_END)
            ts_acc = {ts_acc[55:0], b};
        else if (pos < ID_HIGH_END)
            idh_acc = {idh_acc[55:0], b};
        else if (pos < ID_LOW_END)
            idl_acc = {idl_acc[55:0], b};
        else if (pos < HDR_BYTES)
            decl_len = {decl_len[23:0], b};

        if (byte_pos != COUNT_MAX)
            byte_pos = byte_pos + 17'd1;

        // Payload inside the declared length goes through while the header holds.
        if (pos >= HDR_BYTES && hdr_ok && {15'd0, pos - HDR_BYTES} < decl_len)
        begin
            r       = '0;
            r.kind  = KIND_PAYLOAD;
            r.pbyte = b;
            r.eor   = !last;
            owed_outputs.push_back(r);
        end

        // The final byte closes the frame with a report.
        if (last)
        begin
            r        = '0;
            r.kind   = KIND_REPORT;
            r.dir    = dir_bit;
            r.seq    = seq_acc;
            r.ts     = ts_acc;
            r.idh    = idh_acc;
            r.idl    = idl_acc;
            total    = {16'd0, byte_pos};
            if (byte_pos < HDR_BYTES || !hdr_ok)
                r.status = STATUS_BAD_HDR;
            else if (decl_len > {16'd0, max_len} ||
                     total != {1'b0, decl_len} + {16'd0, HDR_BYTES})
                r.status = STATUS_BAD_SIZE;
            else
                r.status = STATUS_OK;
            r.plen   = (decl_len > PLEN_MAX) ? PLEN_MAX[LENGTH_WIDTH-1:0]
                                             : decl_len[LENGTH_WIDTH-1:0];
            r.eor    = 1'b1;
            owed_outputs.push_back(r);
            clear_frame();
        end
    endfunction

    // Track configuration, predict on accepted input and compare accepted output.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            max_len = MAX_PAYLOAD_RESET;
            owed_outputs.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_wdata;

            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tlast);

            if (m_tvalid && m_tready)
            begin
                got.kind   = m_tuser;
                got.pbyte  = m_tdata[7:0];
                got.dir    = m_tdata[8];
                got.seq    = m_tdata[40:9];
                got.ts     = m_tdata[104:41];
                got.idh    = m_tdata[168:105];
                got.idl    = m_tdata[232:169];
                got.plen   = m_tdata[PLEN_LSB +: LENGTH_WIDTH];
                got.status = m_tdata[STATUS_LSB +: 2];
                got.eor    = m_tlast;
                if (owed_outputs.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= SHOWN_ERRORS)
                        $display("%0t: unexpected item: %s", $realtime, show(got));
                end
                else
                begin
                    want = owed_outputs.pop_front();
                    if (got.kind !== want.kind || got.pbyte !== want.pbyte ||
                        got.dir !== want.dir || got.seq !== want.seq ||
                        got.ts !== want.ts || got.idh !== want.idh ||
                        got.idl !== want.idl || got.plen !== want.plen ||
                        got.status !== want.status || got.eor !== want.eor)
                    begin
                        errors = errors + 1;
                        if (errors <= SHOWN_ERRORS)
                        begin
                            $display("%0t: item mismatch", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end

            pending <= owed_outputs.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import afhd_pkg::*;

    localparam int LENGTH_WIDTH = 16;
    localparam int TDATA_W      = ((235 + LENGTH_WIDTH + 7) / 8) * 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;   // data_byte
    logic               s_tlast = 1'b0; // frame_end
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;        // payload_byte, direction, sequence_res, timestamp,
                                        // stream_id_high, stream_id_low, payload_length,
                                        // status, zero fill
    logic               m_tuser;        // kind
    logic               m_tlast;        // end_of_run

    int errors;
    int pending;
    int tx_idle_pct = 29;
    int rx_idle_pct = 71;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    logic [7:0] frame_q[$];

    always #6 clk = ~clk;

    audio_frame_header_deframer #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    afhd_frame_checker #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offer one byte, with a random gap first, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Start a new frame with a header built from the given fields.
    task automatic begin_frame(input logic [7:0] dir_b, input logic [31:0] decl,
                               input logic [31:0] seq, input logic [63:0] ts,
                               input logic [63:0] idh, input logic [63:0] idl);
        int i;
        frame_q.delete();
        for (i = 0; i < 4; i++)
            frame_q.push_back(MAGIC[i]);
        frame_q.push_back(VERSION);
        frame_q.push_back(dir_b);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        for (i = 3; i >= 0; i--)
            frame_q.push_back(seq[i*8 +: 8]);
        for (i = 7; i >= 0; i--)
            frame_q.push_back(ts[i*8 +: 8]);
        for (i = 7; i >= 0; i--)
            frame_q.push_back(idh[i*8 +: 8]);
        for (i = 7; i >= 0; i--)
            frame_q.push_back(idl[i*8 +: 8]);
        for (i = 3; i >= 0; i--)
            frame_q.push_back(decl[i*8 +: 8]);
    endtask

    task automatic begin_random_frame(input logic [7:0] dir_b, input logic [31:0] decl);
        begin_frame(dir_b, decl, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom});
    endtask

    // Mostly well-formed frames with random content; the rest break one rule.
    task automatic random_frame();
        int          sel;
        int          n_pay;
        int          cut;
        int          i;
        logic [31:0] decl;

        sel  = $urandom_range(0, 99);
        decl = $urandom_range(0, 24);
        if (sel >= 92)
            decl = $urandom;
        begin_random_frame(8'($urandom_range(0, 1)), decl);

        n_pay = (sel >= 92) ? $urandom_range(0, 30) : int'(decl);
        if (sel >= 78 && sel < 85)
        begin
            if (decl != 0 && $urandom_range(0, 1) == 1)
                n_pay = int'(decl) - 1;
            else
                n_pay = int'(decl) + $urandom_range(1, 3);
        end
        for (i = 0; i < n_pay; i++)
            frame_q.push_back(8'($urandom));

        // Corrupt the fixed part of the header, often the direction byte.
        if (sel >= 70 && sel < 78)
        begin
            if ($urandom_range(0, 1) == 1)
                frame_q[5] = 8'($urandom_range(2, 255));
            else
                frame_q[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
        end

        // Short frame that ends inside the header.
        if (sel >= 85 && sel < 92)
        begin
            cut = $urandom_range(1, 39);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end

        // Pure noise.
        if (sel >= 97)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 60))
                frame_q.push_back(8'($urandom));
        end

        send_frame();
    endtask

    // Stop offering items and wait until every owed result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] max_v, input int tx_pct, input int rx_pct,
                             input int n_items, input bit with_hold);
        int start;
        set_max_payload(max_v);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (with_hold)
            hold_requests = hold_requests + 1;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            random_frame();
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset size limit.
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        begin_frame(8'h01, 32'd1, '1, '1, '1, '1);
        frame_q.push_back(8'hFF);
        send_frame();
        begin_frame(8'h00, 32'd0, '0, '0, '0, '0);
        send_frame();

        // Random frames across size limits and idle patterns.
        run_phase(16'hFFFF, 29, 71, 250, 1'b0);
        run_phase(16'($urandom_range(0, 24)), 29, 71, 230, 1'b0);
        run_phase(16'h0000, 71, 29, 200, 1'b0);
        run_phase(16'($urandom_range(0, 24)), 71, 29, 280, 1'b0);
        run_phase(16'($urandom_range(0, 24)), 0, 0, 250, 1'b1);
        run_phase(16'($urandom_range(0, 24)), 0, 0, 160, 1'b0);

        drain();
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/afhd_pkg.sv
rtl/afhd_frame_core.sv
rtl/audio_frame_header_deframer.sv
test/afhd_checker.sv
test/tb.sv
